// ----- rtl/mbps_pkg.sv -----
// Shared constants, codes and types of the masked byte pattern scanner.
package mbps_pkg;

   // Pattern store depth and the limit that the entry index width puts on the length.
   localparam int PATTERN_MAX = 128;
   localparam int INDEX_LIMIT = 128;
   localparam int LEN_LIMIT   = (PATTERN_MAX < INDEX_LIMIT) ? PATTERN_MAX : INDEX_LIMIT;

   // Cell position width (the ring of cells is addressed modulo its size).
   localparam int CELL_W = $clog2(PATTERN_MAX);

   // Field widths fixed by the interface.
   localparam int LEN_W  = 8;
   localparam int ADDR_W = 32;
   localparam int BYTE_W = 8;
   localparam int IDX_W  = 7;

   // Match reduction: cells are ANDed in groups, then the groups are ANDed.
   localparam int GROUP_SIZE  = 16;
   localparam int GROUP_COUNT = PATTERN_MAX / GROUP_SIZE;

   // Result buffer.
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 4);

   // Input operation codes.
   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_SCAN = 1'b1
   } op_type;

   // Configuration register indexes.
   typedef enum logic {
      CSR_PATTERN_LENGTH = 1'b0,
      CSR_REGION_BASE    = 1'b1
   } csr_index_type;

   // Per-cell control for one cycle.
   typedef struct packed {
      logic shift;   // take the neighbor's window byte
      logic rotate;  // take the neighbor's pattern and mask bytes
      logic load;    // write a new pattern and mask entry
   } cell_ctrl_type;

   // One result transaction.
   typedef struct packed {
      logic              found;
      logic [ADDR_W-1:0] match_address;
   } result_type;

endpackage

// ----- rtl/masked_byte_pattern_scanner_unit.sv -----
// Masked byte pattern scanner: finds the first wildcard pattern match in a streamed region.
//
// Load transactions write one pattern entry (stored ANDed with its mask); scan transactions
// push one region byte into a chain of cells, each holding one window byte and one pattern
// entry and comparing them in every cycle. The block takes one transaction per clock cycle,
// loads and scans alike, while req_ready is high; a scan's result, if it has one, passes the
// window shift, cell compare and group AND registers, then the final AND and decision, and
// waits in an 8-entry result buffer before it appears on rsp. Acceptance stops while results
// in flight would overfill that buffer. After a write to pattern_length the pattern ring
// rotates one cell per cycle until it is aligned to the new length; req_ready is low during
// that time, while configuration writes are taken as ever.
module masked_byte_pattern_scanner_unit
   import mbps_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // Input transactions
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_op,
   input  logic [IDX_W-1:0]  req_entry_index,
   input  logic [BYTE_W-1:0] req_pattern_byte,
   input  logic [BYTE_W-1:0] req_mask_byte,
   input  logic [BYTE_W-1:0] req_data_byte,
   input  logic              req_first_of_region,
   input  logic              req_last_of_region,
   // Result transactions
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_found,
   output logic [ADDR_W-1:0] rsp_match_address,
   // Configuration writes
   input  logic              csr_write_enable,
   input  logic              csr_index,
   input  logic [ADDR_W-1:0] csr_wdata
);

   // Configuration and ring alignment.
   logic [LEN_W-1:0]  len_ff, len_in, len_raw;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [CELL_W-1:0] off_ff, off_in, off_target;
   logic              realign;

   // Scan bookkeeping.
   logic [ADDR_W-1:0] cnt_ff, cnt_in, cnt_base;
   logic              mr_ff, mr_in, mr_cur;

   // Pipeline tags.
   logic              s1_v_ff, s1_first_ff, s1_last_ff;
   logic [ADDR_W-1:0] s1_cnt_ff;
   logic              s2_v_ff, s2_first_ff, s2_last_ff, s2_ok_ff;
   logic [ADDR_W-1:0] s2_off_ff;
   logic              s3_v_ff, s3_first_ff, s3_last_ff, s3_ok_ff;
   logic [ADDR_W-1:0] s3_addr_ff;

   // Handshake and control.
   logic               accept, scan_acc, load_acc;
   logic [CELL_W-1:0]  load_cell;
   logic [FIFO_CW-1:0] inflight, fifo_count;
   logic [BYTE_W-1:0]  load_pattern;

   // Cell chain wiring.
   cell_ctrl_type          cell_ctrl [PATTERN_MAX];
   logic [BYTE_W-1:0]      win_q [PATTERN_MAX];
   logic [BYTE_W-1:0]      pat_q [PATTERN_MAX];
   logic [BYTE_W-1:0]      mask_q [PATTERN_MAX];
   logic [PATTERN_MAX-1:0] in_use;
   logic [PATTERN_MAX-1:0] hits;
   logic                   all_hit;

   // Result path.
   logic       push;
   result_type push_data;
   result_type fifo_out;

   // Configuration writes, with the pattern length limited to its usable range.
   always_comb begin
      len_raw = csr_wdata[LEN_W-1:0];
      len_in  = len_ff;
      base_in = base_ff;
      if (csr_write_enable && (csr_index == CSR_PATTERN_LENGTH)) begin
         if (len_raw == '0) begin
            len_in = LEN_W'(1);
         end else if (len_raw > LEN_W'(LEN_LIMIT)) begin
            len_in = LEN_W'(LEN_LIMIT);
         end else begin
            len_in = len_raw;
         end
      end
      if (csr_write_enable && (csr_index == CSR_REGION_BASE)) begin
         base_in = csr_wdata;
      end
   end

   // Cell k holds pattern entry (off - k); the ring rotates until off equals length minus one.
   assign off_target = CELL_W'(len_ff - LEN_W'(1));
   assign realign    = (off_ff != off_target);
   assign off_in     = realign ? off_ff + CELL_W'(1) : off_ff;

   // Acceptance: no realignment running and room for every result in flight.
   assign inflight  = FIFO_CW'(s1_v_ff) + FIFO_CW'(s2_v_ff) + FIFO_CW'(s3_v_ff);
   assign req_ready = !realign && ((fifo_count + inflight) < FIFO_CW'(FIFO_DEPTH));
   assign accept    = req_valid && req_ready;
   assign scan_acc  = accept && (req_op == OP_SCAN);
   assign load_acc  = accept && (req_op == OP_LOAD) && (32'(req_entry_index) < PATTERN_MAX);
   assign load_cell = off_ff - CELL_W'(req_entry_index);

   assign load_pattern = req_pattern_byte & req_mask_byte;

   // Region byte count, cleared by a region start and saturating at its maximum.
   always_comb begin
      cnt_base = req_first_of_region ? '0 : cnt_ff;
      cnt_in   = cnt_ff;
      if (scan_acc) begin
         cnt_in = (cnt_base == '1) ? cnt_base : cnt_base + ADDR_W'(1);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= LEN_W'(1);
         base_ff <= '0;
         off_ff  <= '0;
         cnt_ff  <= '0;
         mr_ff   <= 1'b0;
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         len_ff  <= len_in;
         base_ff <= base_in;
         off_ff  <= off_in;
         cnt_ff  <= cnt_in;
         mr_ff   <= mr_in;
         s1_v_ff <= scan_acc;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
      end
   end

   // Tag payload: count check and offset, then the match address.
   always_ff @(posedge clock) begin
      s1_first_ff <= req_first_of_region;
      s1_last_ff  <= req_last_of_region;
      s1_cnt_ff   <= cnt_in;
      s2_first_ff <= s1_first_ff;
      s2_last_ff  <= s1_last_ff;
      s2_ok_ff    <= (s1_cnt_ff >= ADDR_W'(len_ff));
      s2_off_ff   <= s1_cnt_ff - ADDR_W'(len_ff);
      s3_first_ff <= s2_first_ff;
      s3_last_ff  <= s2_last_ff;
      s3_ok_ff    <= s2_ok_ff;
      s3_addr_ff  <= base_ff + s2_off_ff;
   end

   // Chain of cells: window bytes enter at cell 0, pattern entries form a ring.
   for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
      assign in_use[k]           = (32'(k) < 32'(len_ff));
      assign cell_ctrl[k].shift  = scan_acc;
      assign cell_ctrl[k].rotate = realign;
      assign cell_ctrl[k].load   = load_acc && (load_cell == CELL_W'(k));

      mbps_cell u_cell (
         .clock        (clock),
         .ctrl         (cell_ctrl[k]),
         .in_use       (in_use[k]),
         .win_prev     ((k == 0) ? req_data_byte : win_q[(k + PATTERN_MAX - 1) % PATTERN_MAX]),
         .pat_prev     (pat_q[(k + PATTERN_MAX - 1) % PATTERN_MAX]),
         .mask_prev    (mask_q[(k + PATTERN_MAX - 1) % PATTERN_MAX]),
         .load_pattern (load_pattern),
         .load_mask    (req_mask_byte),
         .win_out      (win_q[k]),
         .pat_out      (pat_q[k]),
         .mask_out     (mask_q[k]),
         .hit          (hits[k])
      );
   end

   mbps_and_tree u_tree (
      .clock   (clock),
      .hits    (hits),
      .all_hit (all_hit)
   );

   // Result decision in transaction order; a region reports once, then stays silent.
   always_comb begin
      mr_cur    = s3_first_ff ? 1'b0 : mr_ff;
      mr_in     = mr_ff;
      push      = 1'b0;
      push_data = '0;
      if (s3_v_ff) begin
         mr_in = mr_cur;
         if (!mr_cur && s3_ok_ff && all_hit) begin
            push                    = 1'b1;
            push_data.found         = 1'b1;
            push_data.match_address = s3_addr_ff;
            mr_in                   = 1'b1;
         end else if (!mr_cur && s3_last_ff) begin
            push  = 1'b1;
            mr_in = 1'b1;
         end else if (s3_last_ff) begin
            mr_in = 1'b1;
         end
      end
   end

   mbps_out_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (rsp_valid && rsp_ready),
      .out_valid (rsp_valid),
      .out_data  (fifo_out),
      .count     (fifo_count)
   );

   assign rsp_found         = fifo_out.found;
   assign rsp_match_address = fifo_out.match_address;

   // Results in flight never exceed the buffer space.
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      (fifo_count + inflight) <= FIFO_CW'(FIFO_DEPTH))
      else $error("result buffer credit exceeded");

   // A found result closes the region.
   a_found_closes: assert property (@(posedge clock) disable iff (reset)
      (push && push_data.found) |=> mr_ff)
      else $error("region not closed after a match");

   // No match is reported before the region holds a full pattern length of bytes.
   a_no_early_match: assert property (@(posedge clock) disable iff (reset)
      (s3_v_ff && !s3_ok_ff) |-> !(push && push_data.found))
      else $error("match reported on a short window");

endmodule

// ----- rtl/mbps_cell.sv -----
// One scanner cell: a window byte, a pattern and mask entry, and a registered compare.
module mbps_cell
   import mbps_pkg::*;
(
   input  logic              clock,
   input  cell_ctrl_type     ctrl,
   input  logic              in_use,
   input  logic [BYTE_W-1:0] win_prev,
   input  logic [BYTE_W-1:0] pat_prev,
   input  logic [BYTE_W-1:0] mask_prev,
   input  logic [BYTE_W-1:0] load_pattern,
   input  logic [BYTE_W-1:0] load_mask,
   output logic [BYTE_W-1:0] win_out,
   output logic [BYTE_W-1:0] pat_out,
   output logic [BYTE_W-1:0] mask_out,
   output logic              hit
);

   logic [BYTE_W-1:0] win_ff, win_in;
   logic [BYTE_W-1:0] pat_ff, pat_in;
   logic [BYTE_W-1:0] mask_ff, mask_in;
   logic              hit_ff, hit_in;

   // Window byte moves one cell further on every scan transaction.
   assign win_in = ctrl.shift ? win_prev : win_ff;

   // Pattern entry is either loaded or rotated along the ring.
   always_comb begin
      pat_in  = pat_ff;
      mask_in = mask_ff;
      if (ctrl.load) begin
         pat_in  = load_pattern;
         mask_in = load_mask;
      end else if (ctrl.rotate) begin
         pat_in  = pat_prev;
         mask_in = mask_prev;
      end
   end

   // A cell beyond the active length never blocks a match.
   assign hit_in = !in_use || ((win_ff & mask_ff) == pat_ff);

   always_ff @(posedge clock) begin
      win_ff  <= win_in;
      pat_ff  <= pat_in;
      mask_ff <= mask_in;
      hit_ff  <= hit_in;
   end

   assign win_out  = win_ff;
   assign pat_out  = pat_ff;
   assign mask_out = mask_ff;
   assign hit      = hit_ff;

endmodule

// ----- rtl/mbps_and_tree.sv -----
// Registered two-level AND reduction of the cell compare results.
module mbps_and_tree
   import mbps_pkg::*;
(
   input  logic                   clock,
   input  logic [PATTERN_MAX-1:0] hits,
   output logic                   all_hit
);

   logic [GROUP_COUNT-1:0] grp_ff, grp_in;

   // First level: one AND per group of cells, registered.
   always_comb begin
      for (int g = 0; g < GROUP_COUNT; g++) begin
         grp_in[g] = &hits[g*GROUP_SIZE +: GROUP_SIZE];
      end
   end

   always_ff @(posedge clock) begin
      grp_ff <= grp_in;
   end

   // Second level feeds the result decision directly.
   assign all_hit = &grp_ff;

endmodule

// ----- rtl/mbps_out_fifo.sv -----
// Result buffer that decouples the scan pipeline from the response channel.
module mbps_out_fifo
   import mbps_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  result_type         push_data,
   input  logic               pop,
   output logic               out_valid,
   output result_type         out_data,
   output logic [FIFO_CW-1:0] count
);

   result_type         mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CW-1:0] count_ff, count_in;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + FIFO_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + FIFO_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + FIFO_CW'(1);
      end else if (!push && pop) begin
         count_in = count_ff - FIFO_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

// ----- tb/tb_masked_byte_pattern_scanner_unit.sv -----
// Self-checking testbench for the masked byte pattern scanner unit.
module tb_masked_byte_pattern_scanner_unit;
   import mbps_pkg::*;

   // Scoreboard: predicts the scan outcome of each accepted transaction and checks results.
   class scan_scoreboard;
      bit [BYTE_W-1:0] pattern_mem [PATTERN_MAX];
      bit [BYTE_W-1:0] mask_mem [PATTERN_MAX];
      bit [BYTE_W-1:0] window [PATTERN_MAX];
      bit [ADDR_W-1:0] bytes_seen;
      bit match_reported;
      bit [LEN_W-1:0] length_reg;
      bit [ADDR_W-1:0] base_reg;
      result_type pending_outcomes [$];
      int unsigned failures;

      function new();
         length_reg = LEN_W'(1);
         base_reg = '0;
         bytes_seen = '0;
         match_reported = 1'b0;
         failures = 0;
      endfunction

      function void write_register(csr_index_type idx, bit [ADDR_W-1:0] data);
         if (idx == CSR_PATTERN_LENGTH)
            length_reg = data[LEN_W-1:0];
         else
            base_reg = data;
      endfunction

      // A length of zero acts as one; anything above the limit is clipped to it.
      function int unsigned active_length();
         int unsigned len;
         len = 32'(length_reg);
         if (len == 0)
            len = 1;
         if (len > LEN_LIMIT)
            len = LEN_LIMIT;
         return len;
      endfunction

      // Window byte 0 is the newest; pattern entry 0 lines up with the oldest compared byte.
      function bit window_matches(int unsigned len);
         for (int j = 0; j < len; j++) begin
            if ((window[len-1-j] & mask_mem[j]) != pattern_mem[j])
               return 1'b0;
         end
         return 1'b1;
      endfunction

      function void record_transaction(op_type op, bit [IDX_W-1:0] idx,
                                       bit [BYTE_W-1:0] pb, mb, db, bit starts, ends);
         int unsigned len;
         result_type outcome;
         if (op == OP_LOAD) begin
            pattern_mem[idx] = pb & mb;
            mask_mem[idx] = mb;
            return;
         end
         if (starts) begin
            bytes_seen = '0;
            match_reported = 1'b0;
         end
         for (int i = PATTERN_MAX - 1; i > 0; i--)
            window[i] = window[i-1];
         window[0] = db;
         if (bytes_seen != '1)
            bytes_seen++;
         len = active_length();
         // The first match wins, even on the final byte; otherwise the region end reports a miss.
         if (!match_reported && bytes_seen >= len && window_matches(len)) begin
            outcome.found = 1'b1;
            outcome.match_address = base_reg + bytes_seen - len;
            pending_outcomes = {pending_outcomes, outcome};
            match_reported = 1'b1;
         end else if (ends && !match_reported) begin
            outcome.found = 1'b0;
            outcome.match_address = '0;
            pending_outcomes = {pending_outcomes, outcome};
            match_reported = 1'b1;
         end else if (ends) begin
            match_reported = 1'b1;
         end
      endfunction

      function void check_outcome(logic found, logic [ADDR_W-1:0] address);
         result_type want;
         if (pending_outcomes.size() == 0) begin
            $error("unexpected result: found=%0b match_address=%h", found, address);
            failures++;
            return;
         end
         want = pending_outcomes.pop_front();
         if (found !== want.found) begin
            $error("found: expected %0b, actual %0b", want.found, found);
            failures++;
         end
         if (address !== want.match_address) begin
            $error("match_address: expected %h, actual %h", want.match_address, address);
            failures++;
         end
      endfunction

      function int unsigned pending();
         return pending_outcomes.size();
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic              req_op;
   logic [IDX_W-1:0]  req_entry_index;
   logic [BYTE_W-1:0] req_pattern_byte;
   logic [BYTE_W-1:0] req_mask_byte;
   logic [BYTE_W-1:0] req_data_byte;
   logic              req_first_of_region;
   logic              req_last_of_region;
   logic              rsp_valid;
   logic              rsp_ready;
   logic              rsp_found;
   logic [ADDR_W-1:0] rsp_match_address;
   logic              csr_write_enable;
   logic              csr_index;
   logic [ADDR_W-1:0] csr_wdata;

   scan_scoreboard board;
   bit entry_loaded [PATTERN_MAX];
   bit sender_idles = 1'b1;
   bit receiver_idles = 1'b1;
   int unsigned items_sent = 0;
   int unsigned stall_requests = 0;
   int unsigned stalls_served = 0;
   int unsigned hold_left = 0;

   masked_byte_pattern_scanner_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_op              (req_op),
      .req_entry_index     (req_entry_index),
      .req_pattern_byte    (req_pattern_byte),
      .req_mask_byte       (req_mask_byte),
      .req_data_byte       (req_data_byte),
      .req_first_of_region (req_first_of_region),
      .req_last_of_region  (req_last_of_region),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_found           (rsp_found),
      .rsp_match_address   (rsp_match_address),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   // Clock with a period of 20.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Run limit, far above the slowest correct run.
   initial begin
      #8_000_000;
      $display("masked_byte_pattern_scanner_unit test failed");
      $finish;
   end

   // Result side: checks each accepted result, idles at random and serves long hold-offs.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            board.check_outcome(rsp_found, rsp_match_address);
         if (stalls_served != stall_requests) begin
            stalls_served = stall_requests;
            hold_left = 300;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !(receiver_idles && $urandom_range(99) < 11);
         end
      end
   end

   // Offers one transaction, with an occasional one-cycle gap first, and waits for its
   // acceptance.
   task automatic send_item(op_type op, bit [IDX_W-1:0] idx,
                            bit [BYTE_W-1:0] pb, mb, db, bit starts, ends);
      if (sender_idles && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_op              <= op;
      req_entry_index     <= idx;
      req_pattern_byte    <= pb;
      req_mask_byte       <= mb;
      req_data_byte       <= db;
      req_first_of_region <= starts;
      req_last_of_region  <= ends;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      board.record_transaction(op, idx, pb, mb, db, starts, ends);
      items_sent++;
   endtask

   // Unused fields of load and scan transactions carry random values.
   task automatic load_entry(bit [IDX_W-1:0] idx, bit [BYTE_W-1:0] pb, mb);
      send_item(OP_LOAD, idx, pb, mb, BYTE_W'($urandom), 1'($urandom), 1'($urandom));
      entry_loaded[idx] = 1'b1;
   endtask

   task automatic scan_byte(bit [BYTE_W-1:0] db, bit starts, ends);
      send_item(OP_SCAN, IDX_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom), db,
                starts, ends);
   endtask

   // Masks are mostly random, with full-compare and all-wildcard entries mixed in.
   task automatic load_random(bit [IDX_W-1:0] idx);
      bit [BYTE_W-1:0] mb;
      int unsigned pick;
      pick = $urandom_range(99);
      mb = BYTE_W'($urandom);
      if (pick < 20)
         mb = 8'hFF;
      else if (pick < 30)
         mb = 8'h00;
      load_entry(idx, BYTE_W'($urandom), mb);
   endtask

   // Stops offering transactions and waits until every expected result is in and the
   // pipeline has settled.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Writes both registers on consecutive cycles; upper write data bits of the length are noise.
   task automatic configure(bit [LEN_W-1:0] len_val, bit [ADDR_W-1:0] base_val);
      bit [ADDR_W-1:0] data;
      data = $urandom;
      data[LEN_W-1:0] = len_val;
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_PATTERN_LENGTH;
      csr_wdata        <= data;
      @(posedge clock);
      board.write_register(CSR_PATTERN_LENGTH, data);
      csr_index        <= CSR_REGION_BASE;
      csr_wdata        <= base_val;
      @(posedge clock);
      board.write_register(CSR_REGION_BASE, base_val);
      csr_write_enable <= 1'b0;
   endtask

   // One region of random bytes, usually with a planted match; a few regions are malformed.
   task automatic run_region(int unsigned span);
      int unsigned total;
      int unsigned start_at;
      int unsigned k;
      bit plant;
      bit opens;
      bit closes;
      bit [BYTE_W-1:0] b;
      plant = $urandom_range(99) < 70;
      start_at = 0;
      if (plant) begin
         total = span + $urandom_range(0, (span > 16) ? 8 : span + 4);
         start_at = $urandom_range(0, total - span);
      end else begin
         total = $urandom_range(1, (span > 16) ? span + 8 : 2 * span + 4);
      end
      opens = $urandom_range(99) < 95;
      closes = $urandom_range(99) < 95;
      for (k = 0; k < total; k++) begin
         b = BYTE_W'($urandom);
         if (plant && k >= start_at && k < start_at + span)
            b = board.pattern_mem[k-start_at] | (b & ~board.mask_mem[k-start_at]);
         if ($urandom_range(99) < 3)
            load_random(IDX_W'($urandom_range(0, span - 1)));
         scan_byte(b, (k == 0) ? opens : ($urandom_range(99) < 1), closes && k == total - 1);
      end
      // Bytes after a region end without a new start are silent.
      if ($urandom_range(99) < 5) begin
         repeat ($urandom_range(1, 3))
            scan_byte(BYTE_W'($urandom), 1'b0, 1'($urandom));
      end
   endtask

   initial begin
      bit [LEN_W-1:0] len_val;
      bit [ADDR_W-1:0] base_val;
      int unsigned eff;
      int unsigned phase;
      board = new();
      reset               <= 1'b1;
      req_valid           <= 1'b0;
      req_op              <= OP_LOAD;
      req_entry_index     <= '0;
      req_pattern_byte    <= '0;
      req_mask_byte       <= '0;
      req_data_byte       <= '0;
      req_first_of_region <= 1'b0;
      req_last_of_region  <= 1'b0;
      csr_write_enable    <= 1'b0;
      csr_index           <= CSR_PATTERN_LENGTH;
      csr_wdata           <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset length of one; bytes before any region start form a region.
      load_entry(IDX_W'(0), 8'hA5, 8'hFF);
      scan_byte(8'h00, 1'b0, 1'b0);
      scan_byte(8'hA5, 1'b0, 1'b0);
      scan_byte(8'hA5, 1'b0, 1'b0);
      scan_byte(8'h11, 1'b0, 1'b1);
      // After a region end, even a region end byte reports nothing.
      scan_byte(8'hA5, 1'b0, 1'b1);
      // One-byte region without a match.
      scan_byte(8'h5A, 1'b1, 1'b1);
      // Match on the final byte gives the match only.
      scan_byte(8'h00, 1'b1, 1'b0);
      scan_byte(8'hA5, 1'b0, 1'b1);
      // Top entry index, an all-wildcard mask and a pattern stored masked.
      load_entry(IDX_W'(127), 8'hFF, 8'h00);
      load_entry(IDX_W'(0), 8'hFF, 8'h0F);
      scan_byte(8'h3F, 1'b1, 1'b1);
      drain();
      // Zero length acts as one; the match address wraps past the top of the address space.
      configure(8'd0, 32'hFFFF_FFFF);
      scan_byte(8'h00, 1'b1, 1'b0);
      scan_byte(8'hFF, 1'b0, 1'b0);
      scan_byte(8'h80, 1'b0, 1'b1);

      // Random phases, each under its own register setting.
      phase = 0;
      while (items_sent < 1400) begin
         drain();
         case (phase)
            0: len_val = 8'd255;
            1: len_val = 8'd128;
            2: len_val = 8'd200;
            3: len_val = 8'd1;
            default: begin
               eff = $urandom_range(99);
               if (eff < 70)
                  len_val = LEN_W'($urandom_range(1, 4));
               else if (eff < 90)
                  len_val = LEN_W'($urandom_range(5, 16));
               else if (eff < 96)
                  len_val = LEN_W'($urandom_range(17, 128));
               else
                  len_val = LEN_W'($urandom_range(0, 255));
            end
         endcase
         eff = $urandom_range(99);
         if (phase == 0 || eff < 10)
            base_val = 32'hFFFF_FFFF - $urandom_range(0, 16);
         else if (phase == 1 || eff < 15)
            base_val = '0;
         else
            base_val = $urandom;
         // A long stretch of phases runs with no idling on either side.
         sender_idles = !(phase >= 5 && phase < 12);
         receiver_idles = sender_idles;
         configure(len_val, base_val);
         eff = board.active_length();

         // Every entry that the scans compare has to be loaded first.
         for (int i = 0; i < eff; i++) begin
            if (!entry_loaded[i])
               load_random(IDX_W'(i));
         end
         repeat ($urandom_range(0, 3))
            load_random(IDX_W'($urandom_range(0, eff - 1)));

         // Hold off the result side while one-byte regions keep coming, so the block backs up.
         if (phase == 6) begin
            stall_requests++;
            repeat (60)
               scan_byte(BYTE_W'($urandom), 1'b1, 1'b1);
         end

         if (eff > 16)
            run_region(eff);
         else
            repeat ($urandom_range(2, 6)) run_region(eff);
         phase++;
      end

      drain();
      if (board.failures == 0)
         $display("masked_byte_pattern_scanner_unit test passed");
      else
         $display("masked_byte_pattern_scanner_unit test failed");
      $finish;
   end

endmodule
